@@ design/pbm_pkg.sv @@
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared constants and types for the paged byte memory with LFU replacement.
// ----------------------------------------------------------------------------
package pbm_pkg;

   // default sizing
   localparam int PHYS_FRAMES_DEF         = 4;
   localparam int MAX_VIRT_PAGES_DEF      = 16;
   localparam int MAX_PAGE_BYTES_LOG2_DEF = 8;

   // fixed field widths
   localparam int KIND_W     = 1;
   localparam int VADDR_W    = 12;
   localparam int BYTE_W     = 8;
   localparam int VICTIM_W   = 4;
   localparam int COUNT_W    = 16;
   localparam int PSL2_W     = 4;
   localparam int VPC_W      = 5;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_IDX_W  = 1;

   // register reset values
   localparam logic [PSL2_W-1:0] PSL2_RESET = PSL2_W'(8);
   localparam logic [VPC_W-1:0]  VPC_RESET  = VPC_W'(16);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE_LOG2     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIRTUAL_PAGE_COUNT = 1'b1;

   // access kinds
   localparam logic [KIND_W-1:0] KIND_READ  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 1'b1;

endpackage

@@ design/pbm_if.sv @@
// ----------------------------------------------------------------------------
// pbm_req_if / pbm_rsp_if
// Valid/ready channels carrying one access word and one result word.
// ----------------------------------------------------------------------------
interface pbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [pbm_pkg::KIND_W-1:0]  kind;
   logic [pbm_pkg::VADDR_W-1:0] virt_address;
   logic [pbm_pkg::BYTE_W-1:0]  write_data;

   modport source (output valid, kind, virt_address, write_data, input ready);
   modport sink   (input valid, kind, virt_address, write_data, output ready);
endinterface

interface pbm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pbm_pkg::BYTE_W-1:0]   read_data;
   logic                         page_fault;
   logic [pbm_pkg::VICTIM_W-1:0] victim_page;
   logic                         address_error;

   modport source (output valid, read_data, page_fault, victim_page, address_error,
                   input ready);
   modport sink   (input valid, read_data, page_fault, victim_page, address_error,
                   output ready);
endinterface

@@ design/paged_byte_memory_lfu_swap_core.sv @@
// ----------------------------------------------------------------------------
// paged_byte_memory_lfu_swap_core
// Byte access through a demand paged memory, evicting the least used page.
// ----------------------------------------------------------------------------
// an address error is answered without a table lookup; a hit goes straight to the
//   access; a fault first runs a table scan and two page copies
// one word in flight; the copies run one byte a cycle through the store ports
// reset: synchronous; afterwards a clearing pass over all MAX_VIRT_PAGES << MAX_PAGE_BYTES_LOG2
//   back-store addresses (4096 by default) zeroes both stores before the first word is taken
module paged_byte_memory_lfu_swap_core #(
   parameter int PHYS_FRAMES         = pbm_pkg::PHYS_FRAMES_DEF,
   parameter int MAX_VIRT_PAGES      = pbm_pkg::MAX_VIRT_PAGES_DEF,
   parameter int MAX_PAGE_BYTES_LOG2 = pbm_pkg::MAX_PAGE_BYTES_LOG2_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   pbm_req_if.sink                           req_chan,
   pbm_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [pbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbm_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int PAGE_W     = (MAX_VIRT_PAGES > 1) ? $clog2(MAX_VIRT_PAGES) : 1;
   localparam int FRAME_W    = (PHYS_FRAMES > 1) ? $clog2(PHYS_FRAMES) : 1;
   localparam int OFF_W      = (MAX_PAGE_BYTES_LOG2 > 0) ? MAX_PAGE_BYTES_LOG2 : 1;
   localparam int CNT_W      = MAX_PAGE_BYTES_LOG2 + 1;
   localparam int PHYS_BYTES = PHYS_FRAMES << MAX_PAGE_BYTES_LOG2;
   localparam int BACK_BYTES = MAX_VIRT_PAGES << MAX_PAGE_BYTES_LOG2;
   localparam int PHYS_AW    = (PHYS_BYTES > 1) ? $clog2(PHYS_BYTES) : 1;
   localparam int BACK_AW    = (BACK_BYTES > 1) ? $clog2(BACK_BYTES) : 1;
   localparam int COUNT_W    = pbm_pkg::COUNT_W;

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_LOOK     = 8'b0000_0100,
      ST_SCAN     = 8'b0000_1000,
      ST_DECIDE   = 8'b0001_0000,
      ST_COPY_OUT = 8'b0010_0000,
      ST_COPY_IN  = 8'b0100_0000,
      ST_ACCESS   = 8'b1000_0000
   } state_type;

   // a finished word waits in ST_IDLE with done flag; use a separate flag
   state_type state_ff, state_in;
   logic      done_ff, done_in;

   // configuration registers
   logic [pbm_pkg::PSL2_W-1:0] psl2_ff;
   logic [pbm_pkg::VPC_W-1:0]  vpc_ff;

   // page tables
   logic [FRAME_W-1:0] frame_of_page_ff [MAX_VIRT_PAGES];
   logic [COUNT_W-1:0] use_count_ff     [MAX_VIRT_PAGES];
   logic [MAX_VIRT_PAGES-1:0] resident_ff;

   // request held
   logic                        kind_ff;
   logic [PAGE_W-1:0]           page_ff;
   logic [OFF_W-1:0]            off_ff;
   logic [pbm_pkg::BYTE_W-1:0]  wdata_ff;
   logic [pbm_pkg::PSL2_W-1:0]  sh_ff;
   logic                        err_ff;

   // replacement
   logic [PAGE_W-1:0]  scan_ff;
   logic [COUNT_W:0]   best_ff;
   logic [PAGE_W-1:0]  victim_ff;
   logic [FRAME_W-1:0] best_frame_ff;
   logic               found_ff;
   logic               fault_ff;
   logic [FRAME_W-1:0] frame_ff;

   // copy engine
   logic [CNT_W-1:0]   cp_cnt_ff;
   logic               cp_pend_ff;
   logic [OFF_W-1:0]   cp_idx_ff;

   // clearing pass
   logic [BACK_AW-1:0] clr_ff;

   // stores
   logic [pbm_pkg::BYTE_W-1:0] phys_mem [PHYS_BYTES];
   logic [pbm_pkg::BYTE_W-1:0] back_mem [BACK_BYTES];
   logic [pbm_pkg::BYTE_W-1:0] phys_q_ff, back_q_ff;

   // result register
   logic                         rsp_valid_ff;
   logic [pbm_pkg::BYTE_W-1:0]   rsp_rdata_ff;
   logic                         rsp_fault_ff;
   logic [pbm_pkg::VICTIM_W-1:0] rsp_victim_ff;
   logic                         rsp_err_ff;

   // address helpers
   function automatic logic [PHYS_AW-1:0] phys_addr(input logic [FRAME_W-1:0] f,
                                                    input logic [pbm_pkg::PSL2_W-1:0] s,
                                                    input logic [OFF_W-1:0] o);
      logic [31:0] a;
      a = (32'(f) << s) | 32'(o);
      return a[PHYS_AW-1:0];
   endfunction

   function automatic logic [BACK_AW-1:0] back_addr(input logic [PAGE_W-1:0] p,
                                                    input logic [pbm_pkg::PSL2_W-1:0] s,
                                                    input logic [OFF_W-1:0] o);
      logic [31:0] a;
      a = (32'(p) << s) | 32'(o);
      return a[BACK_AW-1:0];
   endfunction

   // effective shift and page count
   logic [pbm_pkg::PSL2_W-1:0] eff_sh;
   logic [31:0]                eff_pages;
   logic [31:0]                req_page;
   logic [31:0]                req_mask;
   logic                       req_err;
   logic                       accept;
   logic [CNT_W-1:0]           psize;

   always_comb begin
      if (32'(psl2_ff) > 32'(MAX_PAGE_BYTES_LOG2)) begin
         eff_sh = pbm_pkg::PSL2_W'(MAX_PAGE_BYTES_LOG2);
      end else begin
         eff_sh = psl2_ff;
      end
      eff_pages = 32'(vpc_ff);
      if (eff_pages < 32'(PHYS_FRAMES)) begin
         eff_pages = 32'(PHYS_FRAMES);
      end
      if (eff_pages > 32'(MAX_VIRT_PAGES)) begin
         eff_pages = 32'(MAX_VIRT_PAGES);
      end
      req_page = 32'(req_chan.virt_address) >> eff_sh;
      req_mask = (32'd1 << eff_sh) - 32'd1;
      req_err  = (req_page >= eff_pages);
   end

   assign req_chan.ready = (state_ff == ST_IDLE) && !done_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign psize          = CNT_W'(32'd1 << sh_ff);

   // table read port, shared by lookup and scan
   logic [PAGE_W-1:0]  tab_addr;
   logic               tab_res;
   logic [COUNT_W-1:0] tab_count;
   logic [FRAME_W-1:0] tab_frame;

   assign tab_addr  = (state_ff == ST_SCAN) ? scan_ff : page_ff;
   assign tab_res   = resident_ff[tab_addr];
   assign tab_count = use_count_ff[tab_addr];
   assign tab_frame = frame_of_page_ff[tab_addr];

   // copy control
   logic cp_issue;
   logic cp_last;
   assign cp_issue = ((state_ff == ST_COPY_OUT) || (state_ff == ST_COPY_IN))
                     && (cp_cnt_ff < psize);
   assign cp_last  = (cp_cnt_ff == psize);

   // store port control
   logic                       phys_we, phys_re, back_we, back_re;
   logic [PHYS_AW-1:0]         phys_waddr, phys_raddr;
   logic [BACK_AW-1:0]         back_waddr, back_raddr;
   logic [pbm_pkg::BYTE_W-1:0] phys_wdata, back_wdata;

   always_comb begin
      phys_we    = 1'b0;
      phys_re    = 1'b0;
      back_we    = 1'b0;
      back_re    = 1'b0;
      phys_waddr = phys_addr(frame_ff, sh_ff, cp_idx_ff);
      phys_raddr = phys_addr(frame_ff, sh_ff, OFF_W'(cp_cnt_ff));
      back_waddr = back_addr(victim_ff, sh_ff, cp_idx_ff);
      back_raddr = back_addr(page_ff, sh_ff, OFF_W'(cp_cnt_ff));
      phys_wdata = back_q_ff;
      back_wdata = phys_q_ff;
      case (state_ff)
         ST_CLEAR: begin
            phys_we    = 1'b1;
            back_we    = 1'b1;
            phys_waddr = PHYS_AW'(clr_ff);
            back_waddr = clr_ff;
            phys_wdata = '0;
            back_wdata = '0;
         end
         ST_COPY_OUT: begin
            phys_re = cp_issue;
            back_we = cp_pend_ff;
         end
         ST_COPY_IN: begin
            back_re = cp_issue;
            phys_we = cp_pend_ff;
         end
         ST_ACCESS: begin
            phys_waddr = phys_addr(frame_ff, sh_ff, off_ff);
            phys_raddr = phys_addr(frame_ff, sh_ff, off_ff);
            phys_wdata = wdata_ff;
            phys_we    = (kind_ff == pbm_pkg::KIND_WRITE);
            phys_re    = (kind_ff == pbm_pkg::KIND_READ);
         end
         default: begin
         end
      endcase
   end

   // stores
   always_ff @(posedge clock) begin
      if (phys_we) begin
         phys_mem[phys_waddr] <= phys_wdata;
      end
      if (phys_re) begin
         phys_q_ff <= phys_mem[phys_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem[back_waddr] <= back_wdata;
      end
      if (back_re) begin
         back_q_ff <= back_mem[back_raddr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (done_ff) begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  done_in = 1'b0;
               end
            end else if (accept) begin
               state_in = req_err ? ST_IDLE : ST_LOOK;
               done_in  = req_err;
            end
         end
         ST_LOOK: begin
            state_in = tab_res ? ST_ACCESS : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff == PAGE_W'(MAX_VIRT_PAGES - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = found_ff ? ST_COPY_OUT : ST_COPY_IN;
         end
         ST_COPY_OUT: begin
            if (cp_last) begin
               state_in = ST_COPY_IN;
            end
         end
         ST_COPY_IN: begin
            if (cp_last) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers and tables
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         done_ff      <= 1'b0;
         clr_ff       <= '0;
         psl2_ff      <= pbm_pkg::PSL2_RESET;
         vpc_ff       <= pbm_pkg::VPC_RESET;
         rsp_valid_ff <= 1'b0;
         cp_pend_ff   <= 1'b0;
         cp_cnt_ff    <= '0;
         for (int i = 0; i < MAX_VIRT_PAGES; i++) begin
            frame_of_page_ff[i] <= (i < PHYS_FRAMES) ? FRAME_W'(i) : '0;
            use_count_ff[i]     <= '0;
            resident_ff[i]      <= (i < PHYS_FRAMES);
         end
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;

         // configuration writes
         if (csr_write_enable) begin
            case (csr_index)
               pbm_pkg::CSR_PAGE_SIZE_LOG2:
                  psl2_ff <= csr_write_data[pbm_pkg::PSL2_W-1:0];
               pbm_pkg::CSR_VIRTUAL_PAGE_COUNT:
                  vpc_ff <= csr_write_data[pbm_pkg::VPC_W-1:0];
               default: begin
               end
            endcase
         end

         // clearing pass
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + BACK_AW'(1);
         end

         // hit: bump use count, saturating
         if (state_ff == ST_LOOK && tab_res && tab_count != '1) begin
            use_count_ff[page_ff] <= tab_count + COUNT_W'(1);
         end

         // table update once the victim is known
         if (state_ff == ST_DECIDE) begin
            if (found_ff) begin
               resident_ff[victim_ff] <= 1'b0;
            end
            frame_of_page_ff[page_ff] <= found_ff ? best_frame_ff : '0;
            resident_ff[page_ff]      <= 1'b1;
            use_count_ff[page_ff]     <= '0;
         end

         // copy engine: read one byte a cycle, write it in the cycle after
         cp_pend_ff <= cp_issue;
         if (cp_issue) begin
            cp_cnt_ff <= cp_cnt_ff + CNT_W'(1);
         end else begin
            cp_cnt_ff <= '0;
         end

         // result register
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && done_ff && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   logic [31:0] victim_wide;
   assign victim_wide = 32'(victim_ff);

   always_ff @(posedge clock) begin
      cp_idx_ff <= OFF_W'(cp_cnt_ff);

      if (accept) begin
         kind_ff  <= req_chan.kind;
         page_ff  <= PAGE_W'(req_page);
         off_ff   <= OFF_W'(32'(req_chan.virt_address) & req_mask);
         wdata_ff <= req_chan.write_data;
         sh_ff    <= eff_sh;
         err_ff   <= req_err;
         fault_ff <= 1'b0;
      end

      // lookup: remember frame on hit, arm search on miss
      if (state_ff == ST_LOOK) begin
         frame_ff <= tab_frame;
         scan_ff  <= '0;
         best_ff  <= {1'b1, {COUNT_W{1'b0}}};
         found_ff <= 1'b0;
         fault_ff <= !tab_res;
      end

      // search: least count, first index wins ties
      if (state_ff == ST_SCAN) begin
         scan_ff <= scan_ff + PAGE_W'(1);
         if (tab_res && {1'b0, tab_count} < best_ff) begin
            best_ff       <= {1'b0, tab_count};
            victim_ff     <= scan_ff;
            best_frame_ff <= tab_frame;
            found_ff      <= 1'b1;
         end
      end

      if (state_ff == ST_DECIDE) begin
         frame_ff <= found_ff ? best_frame_ff : '0;
      end

      if (state_ff == ST_IDLE && done_ff && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_err_ff    <= err_ff;
         rsp_fault_ff  <= !err_ff && fault_ff;
         rsp_victim_ff <= (!err_ff && fault_ff && found_ff) ?
                          victim_wide[pbm_pkg::VICTIM_W-1:0] : '0;
         rsp_rdata_ff  <= (!err_ff && kind_ff == pbm_pkg::KIND_READ) ? phys_q_ff : '0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_data     = rsp_rdata_ff;
   assign rsp_chan.page_fault    = rsp_fault_ff;
   assign rsp_chan.victim_page   = rsp_victim_ff;
   assign rsp_chan.address_error = rsp_err_ff;

`ifndef NO_ASSERTIONS
   // never more resident pages than frames
   a_resident_bound: assert property (@(posedge clock) disable iff (reset)
      $countones(resident_ff) <= PHYS_FRAMES)
      else $error("more resident pages than frames");

   // no word taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_chan.ready)
      else $error("accept during clearing pass");

   // copy counter stays within one page
   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY_OUT || state_ff == ST_COPY_IN) |-> cp_cnt_ff <= psize)
      else $error("copy counter past page end");

   // requested page is resident once the swap is decided
   a_swap_resident: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |=> resident_ff[page_ff])
      else $error("requested page not resident after swap");

   // fault and address error never together
   a_fault_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_fault_ff && rsp_err_ff))
      else $error("fault reported with address error");
`endif

endmodule

@@ tb/sv/paged_byte_memory_lfu_swap_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_byte_memory_lfu_swap_core_test
// Drives byte reads and writes through the paged memory under several page
// size and page count settings. Each result word is checked against a local
// model of the frame table, the use counts and both stores.
// ----------------------------------------------------------------------------
module paged_byte_memory_lfu_swap_core_test;

   localparam int FRAMES     = pbm_pkg::PHYS_FRAMES_DEF;
   localparam int VPAGES     = pbm_pkg::MAX_VIRT_PAGES_DEF;
   localparam int SHIFT_MAX  = pbm_pkg::MAX_PAGE_BYTES_LOG2_DEF;
   localparam int PHYS_BYTES = FRAMES << SHIFT_MAX;
   localparam int BACK_BYTES = VPAGES << SHIFT_MAX;
   localparam int COUNT_TOP  = 16'hFFFF;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 600;

   typedef struct packed {
      logic [pbm_pkg::KIND_W-1:0]  kind;
      logic [pbm_pkg::VADDR_W-1:0] addr;
      logic [pbm_pkg::BYTE_W-1:0]  wdata;
   } access_type;

   typedef struct packed {
      logic [pbm_pkg::BYTE_W-1:0]   read_data;
      logic                         page_fault;
      logic [pbm_pkg::VICTIM_W-1:0] victim_page;
      logic                         address_error;
   } outcome_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [pbm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pbm_pkg::CSR_DATA_W-1:0] csr_write_data;

   pbm_req_if req_chan ();
   pbm_rsp_if rsp_chan ();

   paged_byte_memory_lfu_swap_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // local copy of the memory state
   logic [pbm_pkg::PSL2_W-1:0]  cfg_shift;
   logic [pbm_pkg::VPC_W-1:0]   cfg_pages;
   logic [1:0]                  frame_map [VPAGES];
   logic [pbm_pkg::COUNT_W-1:0] hit_count [VPAGES];
   bit                          resident  [VPAGES];
   logic [7:0]                  phys_mem  [PHYS_BYTES];
   logic [7:0]                  back_mem  [BACK_BYTES];

   access_type  pending_words [$];
   outcome_type expected_outcomes [$];
   int          fail_count = 0;
   int          idle_cycles = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int eff_shift();
      return (int'(cfg_shift) > SHIFT_MAX) ? SHIFT_MAX : int'(cfg_shift);
   endfunction

   function automatic int eff_pages();
      int n;
      n = int'(cfg_pages);
      if (n < FRAMES) n = FRAMES;
      if (n > VPAGES) n = VPAGES;
      return n;
   endfunction

   function automatic void clear_memory_state();
      for (int i = 0; i < VPAGES; i++) begin
         resident[i]  = (i < FRAMES);
         frame_map[i] = (i < FRAMES) ? 2'(i) : 2'd0;
         hit_count[i] = '0;
      end
      for (int i = 0; i < PHYS_BYTES; i++) phys_mem[i] = '0;
      for (int i = 0; i < BACK_BYTES; i++) back_mem[i] = '0;
      cfg_shift = pbm_pkg::PSL2_RESET;
      cfg_pages = pbm_pkg::VPC_RESET;
   endfunction

   // apply one access to the local state and return its result word
   function automatic outcome_type apply_access(access_type a);
      outcome_type o;
      int sh, psize, page, off, frame, victim, best, idx;
      bit found;
      o = '0;
      sh = eff_shift();
      psize = 1 << sh;
      page = int'(a.addr) >> sh;
      off = int'(a.addr) & (psize - 1);
      if (page >= eff_pages()) begin
         o.address_error = 1'b1;
         return o;
      end
      if (resident[page]) begin
         if (int'(hit_count[page]) < COUNT_TOP)
            hit_count[page] = hit_count[page] + pbm_pkg::COUNT_W'(1);
      end else begin
         // least used resident page, lowest index wins ties
         best = COUNT_TOP + 1;
         victim = 0;
         found = 0;
         for (int i = 0; i < VPAGES; i++) begin
            if (resident[i] && int'(hit_count[i]) < best) begin
               best = int'(hit_count[i]);
               victim = i;
               found = 1;
            end
         end
         frame = 0;
         if (found) begin
            frame = int'(frame_map[victim]);
            for (int i = 0; i < psize; i++)
               if (frame * psize + i < PHYS_BYTES && victim * psize + i < BACK_BYTES)
                  back_mem[victim * psize + i] = phys_mem[frame * psize + i];
            resident[victim] = 0;
         end
         for (int i = 0; i < psize; i++)
            if (page * psize + i < BACK_BYTES && frame * psize + i < PHYS_BYTES)
               phys_mem[frame * psize + i] = back_mem[page * psize + i];
         frame_map[page] = 2'(frame);
         resident[page] = 1;
         hit_count[page] = '0;
         o.page_fault = 1'b1;
         o.victim_page = pbm_pkg::VICTIM_W'(victim);
      end
      idx = int'(frame_map[page]) * psize + off;
      if (idx < PHYS_BYTES) begin
         if (a.kind == pbm_pkg::KIND_WRITE) phys_mem[idx] = a.wdata;
         else o.read_data = phys_mem[idx];
      end
      return o;
   endfunction

   // driver: bursts of words with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.kind <= pbm_pkg::KIND_READ;
         req_chan.virt_address <= '0;
         req_chan.write_data <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_outcomes.push_back(apply_access(
               {req_chan.kind, req_chan.virt_address, req_chan.write_data}));
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               access_type a;
               a = pending_words.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.kind <= a.kind;
               req_chan.virt_address <= a.addr;
               req_chan.write_data <= a.wdata;
               if (burst_left > 0) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls, with calm stretches where no new stall starts
   int stall_left = 0;
   int calm_timer = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         calm_timer = (calm_timer + 1) % 400;
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (calm_timer >= 150 && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 12);
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            outcome_type e;
            e = expected_outcomes.pop_front();
            if (rsp_chan.read_data !== e.read_data) begin
               $error("read_data exp %0d got %0d", e.read_data, rsp_chan.read_data);
               fail_count++;
            end
            if (rsp_chan.page_fault !== e.page_fault) begin
               $error("page_fault exp %0d got %0d", e.page_fault, rsp_chan.page_fault);
               fail_count++;
            end
            if (rsp_chan.victim_page !== e.victim_page) begin
               $error("victim_page exp %0d got %0d", e.victim_page, rsp_chan.victim_page);
               fail_count++;
            end
            if (rsp_chan.address_error !== e.address_error) begin
               $error("address_error exp %0d got %0d", e.address_error,
                      rsp_chan.address_error);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted word or result
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_csr(logic [pbm_pkg::CSR_IDX_W-1:0] idx,
                            logic [pbm_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == pbm_pkg::CSR_PAGE_SIZE_LOG2) cfg_shift = value[pbm_pkg::PSL2_W-1:0];
      else cfg_pages = value[pbm_pkg::VPC_W-1:0];
   endtask

   // sample on the falling edge so the driver's updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (!(pending_words.size() == 0 && !req_chan.valid
               && expected_outcomes.size() == 0));
      repeat (4) @(posedge clock);
   endtask

   function automatic void push_word(logic [pbm_pkg::KIND_W-1:0] k, int addr, int data);
      access_type a;
      a.kind = k;
      a.addr = pbm_pkg::VADDR_W'(addr);
      a.wdata = pbm_pkg::BYTE_W'(data);
      pending_words.push_back(a);
   endfunction

   // mostly a small hot set of pages so hits and counts build up
   function automatic void push_random_word();
      int sh, page, addr, pick;
      sh = eff_shift();
      pick = $urandom_range(0, 99);
      if (pick < 60) page = int'($urandom_range(0, 5)) % eff_pages();
      else if (pick < 85) page = $urandom_range(0, eff_pages() - 1);
      else page = -1;
      if (page < 0) addr = $urandom_range(0, 4095);
      else addr = ((page << sh) | ($urandom_range(0, 4095) & ((1 << sh) - 1))) & 12'hFFF;
      push_word(pbm_pkg::KIND_W'($urandom_range(0, 1)), addr, $urandom_range(0, 255));
   endfunction

   task automatic run_setting(int shift, int pages, int count);
      write_csr(pbm_pkg::CSR_PAGE_SIZE_LOG2, pbm_pkg::CSR_DATA_W'(shift));
      write_csr(pbm_pkg::CSR_VIRTUAL_PAGE_COUNT, pbm_pkg::CSR_DATA_W'(pages));
      for (int i = 0; i < count; i++) push_random_word();
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = pbm_pkg::CSR_PAGE_SIZE_LOG2;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.kind = pbm_pkg::KIND_READ;
      req_chan.virt_address = '0;
      req_chan.write_data = '0;
      rsp_chan.ready = 1'b0;
      clear_memory_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, hits, faults and evictions at reset setting
      push_word(pbm_pkg::KIND_READ, 0, 0);
      push_word(pbm_pkg::KIND_WRITE, 0, 255);
      push_word(pbm_pkg::KIND_READ, 0, 0);
      push_word(pbm_pkg::KIND_WRITE, 12'h3FF, 8'hA5);
      push_word(pbm_pkg::KIND_READ, 12'h3FF, 0);
      push_word(pbm_pkg::KIND_WRITE, 12'hFFF, 8'h5A);
      push_word(pbm_pkg::KIND_READ, 12'hFFF, 0);
      push_word(pbm_pkg::KIND_READ, 12'h400, 0);
      push_word(pbm_pkg::KIND_READ, 0, 0);
      push_word(pbm_pkg::KIND_READ, 12'h3FF, 0);
      push_word(pbm_pkg::KIND_WRITE, 12'h800, 8'h01);
      wait_drained();

      // directed: page count clamped up, addresses beyond the pages
      write_csr(pbm_pkg::CSR_VIRTUAL_PAGE_COUNT, 5'd0);
      push_word(pbm_pkg::KIND_WRITE, 12'h400, 8'h77);
      push_word(pbm_pkg::KIND_READ, 12'hFFF, 0);
      push_word(pbm_pkg::KIND_READ, 12'h3FF, 0);
      push_word(pbm_pkg::KIND_READ, 12'h000, 0);
      wait_drained();

      // directed: page size too large acts as the largest size
      write_csr(pbm_pkg::CSR_PAGE_SIZE_LOG2, 5'd15);
      write_csr(pbm_pkg::CSR_VIRTUAL_PAGE_COUNT, 5'd31);
      push_word(pbm_pkg::KIND_READ, 12'hFFF, 0);
      push_word(pbm_pkg::KIND_READ, 12'h800, 0);
      push_word(pbm_pkg::KIND_WRITE, 12'hC00, 8'hFF);
      wait_drained();

      // random phases over a spread of settings
      run_setting(8, 16, 110);
      run_setting(0, 4, 110);
      run_setting(2, 5, 110);
      run_setting(4, 10, 110);
      run_setting(15, 31, 90);
      run_setting(3, 0, 110);
      run_setting(1, 16, 110);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_outcomes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
